// File: rtl/core/ascii_command_keyword_parser_defines.svh
// Assertion macros for the command keyword parser RTL.
`ifndef ASCII_COMMAND_KEYWORD_PARSER_DEFINES_SVH
`define ASCII_COMMAND_KEYWORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define CAKP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cakp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CAKP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cakp: next-cycle check failed");

`else

`define CAKP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CAKP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/cakp_pkg.sv
// Types, keyword tables and matching functions of the command keyword parser.
`default_nettype none

package cakp_pkg;

    localparam int KW_COUNT  = 5;
    localparam int KW_MAXLEN = 6;

    // Bit positions in the first-token hit vector.
    localparam int FIRST_STATUS = 0;
    localparam int FIRST_MODE   = 1;
    localparam int FIRST_BT     = 2;
    localparam int FIRST_TC     = 3;
    localparam int FIRST_ALL    = 4;

    // Bit positions in the second-token hit vector.
    localparam int SECOND_AUTO = 0;
    localparam int SECOND_BT   = 1;
    localparam int SECOND_TC   = 2;
    localparam int SECOND_OFF  = 3;
    localparam int SECOND_ON   = 4;

    typedef logic [KW_COUNT-1:0] kw_hits_t;

    localparam kw_hits_t HITS_ALL = '1;

    localparam logic [7:0] FIRST_WORDS [KW_COUNT][KW_MAXLEN] = '{
        '{"S", "T", "A", "T", "U", "S"},
        '{"M", "O", "D", "E", 8'h00, 8'h00},
        '{"B", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "C", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "L", "L", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] FIRST_LENS [KW_COUNT] = '{3'd6, 3'd4, 3'd2, 3'd2, 3'd3};

    localparam logic [7:0] SECOND_WORDS [KW_COUNT][KW_MAXLEN] = '{
        '{"A", "U", "T", "O", 8'h00, 8'h00},
        '{"B", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "C", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00},
        '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] SECOND_LENS [KW_COUNT] = '{3'd4, 3'd2, 3'd2, 3'd3, 3'd2};

    localparam logic [1:0] TOKEN_COUNT_MAX = 2'd3;
    localparam logic [2:0] CHAR_POS_MAX    = 3'd7;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_STATUS     = 2'd1,
        RES_FORMAT_ERR = 2'd2
    } result_code_t;

    typedef enum logic [2:0] {
        CMD_BT_ON     = 3'd0,
        CMD_BT_OFF    = 3'd1,
        CMD_TC_ON     = 3'd2,
        CMD_TC_OFF    = 3'd3,
        CMD_BOTH_ON   = 3'd4,
        CMD_BOTH_OFF  = 3'd5,
        CMD_BT_ONLY   = 3'd6,
        CMD_TC_ONLY   = 3'd7
    } command_code_t;

    typedef struct packed {
        logic [1:0] token_count;
        logic       inside_token;
        logic [2:0] char_position;
        kw_hits_t   first_hits;
        kw_hits_t   second_hits;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        token_count:   2'd0,
        inside_token:  1'b0,
        char_position: 3'd0,
        first_hits:    HITS_ALL,
        second_hits:   HITS_ALL
    };

    typedef struct packed {
        command_code_t command_code;
        result_code_t  result_code;
    } parse_result_t;

    function automatic logic is_separator(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h61:8'h7A]}) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    // Drops every keyword that is too short for this position or whose letter there differs from the byte.
    function automatic kw_hits_t match_byte(input kw_hits_t hits, input logic second,
                                            input logic [2:0] pos, input logic [7:0] u);
        kw_hits_t   r;
        logic [7:0] ch;
        logic [2:0] len;
        r = hits;
        for (int k = 0; k < KW_COUNT; k++) begin
            ch = 8'h00;
            for (int p = 0; p < KW_MAXLEN; p++) begin
                if (pos == 3'(p)) begin
                    ch = second ? SECOND_WORDS[k][p] : FIRST_WORDS[k][p];
                end
            end
            len = second ? SECOND_LENS[k] : FIRST_LENS[k];
            if (!((pos < len) && (ch == u))) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // A finished token keeps only the keywords of exactly its length.
    function automatic kw_hits_t match_length(input kw_hits_t hits, input logic second,
                                              input logic [2:0] pos);
        kw_hits_t   r;
        logic [2:0] len;
        r = hits;
        for (int k = 0; k < KW_COUNT; k++) begin
            len = second ? SECOND_LENS[k] : FIRST_LENS[k];
            if (pos != len) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic parse_state_t close_token(input parse_state_t st);
        parse_state_t r;
        r = st;
        if (st.inside_token) begin
            if (st.token_count == 2'd1) begin
                r.first_hits = match_length(st.first_hits, 1'b0, st.char_position);
            end else if (st.token_count == 2'd2) begin
                r.second_hits = match_length(st.second_hits, 1'b1, st.char_position);
            end
            r.inside_token = 1'b0;
        end
        return r;
    endfunction

    function automatic parse_result_t decide(input parse_state_t st);
        parse_result_t r;
        kw_hits_t      f;
        kw_hits_t      s;
        logic          off;
        f = st.first_hits;
        s = st.second_hits;
        r.result_code  = RES_FORMAT_ERR;
        r.command_code = CMD_BT_ON;
        off = !s[SECOND_ON];
        if (st.token_count == 2'd1) begin
            if (f[FIRST_STATUS]) begin
                r.result_code = RES_STATUS;
            end
        end else if (st.token_count == 2'd2) begin
            if (f[FIRST_MODE]) begin
                if (s[SECOND_AUTO]) begin
                    r.result_code  = RES_OK;
                    r.command_code = CMD_BOTH_ON;
                end else if (s[SECOND_BT]) begin
                    r.result_code  = RES_OK;
                    r.command_code = CMD_BT_ONLY;
                end else if (s[SECOND_TC]) begin
                    r.result_code  = RES_OK;
                    r.command_code = CMD_TC_ONLY;
                end else if (s[SECOND_OFF]) begin
                    r.result_code  = RES_OK;
                    r.command_code = CMD_BOTH_OFF;
                end
            end else if (s[SECOND_ON] || s[SECOND_OFF]) begin
                if (f[FIRST_BT]) begin
                    r.result_code  = RES_OK;
                    r.command_code = off ? CMD_BT_OFF : CMD_BT_ON;
                end else if (f[FIRST_TC]) begin
                    r.result_code  = RES_OK;
                    r.command_code = off ? CMD_TC_OFF : CMD_TC_ON;
                end else if (f[FIRST_ALL]) begin
                    r.result_code  = RES_OK;
                    r.command_code = off ? CMD_BOTH_OFF : CMD_BOTH_ON;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cakp_byte_step.sv
// Combinational update of the parse state for one frame byte, with the frame verdict.
`default_nettype none

module cakp_byte_step
    import cakp_pkg::*;
(
    input  parse_state_t  state_i,
    input  logic [7:0]    frame_byte_i,
    input  logic          end_of_frame_i,
    output parse_state_t  state_next_o,
    output parse_result_t result_o
);

    parse_state_t st;
    parse_state_t closed;
    logic [7:0]   upper;

    assign upper = to_upper(frame_byte_i);

    always_comb begin
        st = state_i;
        if (is_separator(frame_byte_i)) begin
            st = close_token(state_i);
        end else begin
            if (!state_i.inside_token) begin
                st.inside_token  = 1'b1;
                st.char_position = 3'd0;
                if (state_i.token_count != TOKEN_COUNT_MAX) begin
                    st.token_count = state_i.token_count + 2'd1;
                end
            end
            // Only the first two tokens are matched; later ones just count.
            if (st.token_count == 2'd1) begin
                st.first_hits = match_byte(st.first_hits, 1'b0, st.char_position, upper);
            end else if (st.token_count == 2'd2) begin
                st.second_hits = match_byte(st.second_hits, 1'b1, st.char_position, upper);
            end
            if (st.char_position != CHAR_POS_MAX) begin
                st.char_position = st.char_position + 3'd1;
            end
        end
    end

    always_comb begin
        closed       = close_token(st);
        result_o     = decide(closed);
        state_next_o = end_of_frame_i ? PARSE_RESET : st;
    end

endmodule

`default_nettype wire

// File: rtl/core/ascii_command_keyword_parser.sv
// Top level of the ASCII command keyword parser: input register, parse state and result register.
`default_nettype none

// Takes one frame byte per beat on the slave side (tlast marks the last byte of a frame) and
// returns one beat on the master side per frame, carrying the result and command codes.
// Bytes are accepted at one per clock cycle without gaps unless a closing byte waits in the
// input register for a free result register, which is loaded as that byte is processed. The
// rate is set by the single parse-state update per byte, placed between the input register
// and the state and result registers. While a result is held back by the master side, bytes
// of the next frame keep flowing until that frame's closing byte reaches the state update.

`include "ascii_command_keyword_parser_defines.svh"

module ascii_command_keyword_parser
    import cakp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] frame_byte
    input  wire logic       s_tlast,    // end_of_frame

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata     // [1:0] result_code, [4:2] command_code, [7:5] zero
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;

    parse_state_t  state_reg;
    parse_state_t  state_next;

    logic          m_valid_reg;
    logic          m_valid_next;
    parse_result_t result_reg;
    parse_result_t step_result;

    logic          out_free;
    logic          proc_fire;
    logic          s_fire;

    assign out_free  = !m_valid_reg || m_tready;
    // A byte that closes no frame does not need the result register.
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    cakp_byte_step u_step (
        .state_i        (state_reg),
        .frame_byte_i   (in_byte_reg),
        .end_of_frame_i (in_last_reg),
        .state_next_o   (state_next),
        .result_o       (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc_fire && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= PARSE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (proc_fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && in_last_reg) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, result_reg.command_code, result_reg.result_code};

    `CAKP_ASSERT_NEXT(a_frame_end_gives_result, aclk, aresetn,
        proc_fire && in_last_reg, m_valid_reg)
    `CAKP_ASSERT_NEXT(a_frame_end_clears_state, aclk, aresetn,
        proc_fire && in_last_reg, state_reg == PARSE_RESET)
    `CAKP_ASSERT_SAME(a_no_result_overwrite, aclk, aresetn,
        m_valid_reg && !m_tready, !(proc_fire && in_last_reg))
    `CAKP_ASSERT_SAME(a_command_zero_unless_ok, aclk, aresetn,
        m_valid_reg && (result_reg.result_code != RES_OK),
        result_reg.command_code == CMD_BT_ON)

endmodule

`default_nettype wire

// File: tb/ascii_command_keyword_parser_tb.sv
// Self-checking testbench for the ASCII command keyword parser: frames in, verdicts out.
`timescale 1ns / 100ps

module ascii_command_keyword_parser_tb;
    import cakp_pkg::*;

    localparam int BYTE_TARGET = 450;
    localparam int IDLE_LIMIT  = 1000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       wait_idle;   // hold this beat back until no verdict is outstanding
    } frame_beat_t;

    typedef struct {
        result_code_t  rc;
        command_code_t cc;
    } verdict_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    frame_beat_t beat_q[$];
    verdict_t    verdict_q[$];
    logic [7:0]  frame_buf[$];
    string       phrase[$];
    int          send_idx    = 0;
    int          err_count   = 0;
    int          frame_count = 0;
    int          n_cmd       = 0;
    int          n_status    = 0;
    int          n_format    = 0;

    // Shadow parse state.
    logic [1:0] p_tokens;
    logic       p_in_word;
    logic [2:0] p_pos;
    kw_hits_t   p_head_hits;
    kw_hits_t   p_arg_hits;

    ascii_command_keyword_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic string head_word(input int k);
        case (k)
            FIRST_STATUS: return "STATUS";
            FIRST_MODE:   return "MODE";
            FIRST_BT:     return "BT";
            FIRST_TC:     return "TC";
            default:      return "ALL";
        endcase
    endfunction

    function automatic string arg_word(input int k);
        case (k)
            SECOND_AUTO: return "AUTO";
            SECOND_BT:   return "BT";
            SECOND_TC:   return "TC";
            SECOND_OFF:  return "OFF";
            default:     return "ON";
        endcase
    endfunction

    function automatic string any_word(input int k);
        return (k < 5) ? head_word(k) : arg_word(k - 5);
    endfunction

    // Drops every keyword that cannot have this letter at this position.
    function automatic kw_hits_t prune_letter(input kw_hits_t h, input bit is_arg,
                                              input logic [2:0] pos, input logic [7:0] u);
        string w;
        for (int k = 0; k < 5; k++) begin
            w = is_arg ? arg_word(k) : head_word(k);
            if (!(pos < w.len() && w[pos] == u)) begin
                h[k] = 1'b0;
            end
        end
        return h;
    endfunction

    function automatic kw_hits_t prune_length(input kw_hits_t h, input bit is_arg,
                                              input logic [2:0] pos);
        string w;
        for (int k = 0; k < 5; k++) begin
            w = is_arg ? arg_word(k) : head_word(k);
            if (pos != w.len()) begin
                h[k] = 1'b0;
            end
        end
        return h;
    endfunction

    task automatic clear_parse();
        p_tokens    = 2'd0;
        p_in_word   = 1'b0;
        p_pos       = 3'd0;
        p_head_hits = '1;
        p_arg_hits  = '1;
    endtask

    task automatic end_word();
        if (p_in_word) begin
            if (p_tokens == 2'd1) begin
                p_head_hits = prune_length(p_head_hits, 1'b0, p_pos);
            end else if (p_tokens == 2'd2) begin
                p_arg_hits = prune_length(p_arg_hits, 1'b1, p_pos);
            end
            p_in_word = 1'b0;
        end
    endtask

    function automatic verdict_t judge();
        verdict_t v;
        logic     off;
        v.rc = RES_FORMAT_ERR;
        v.cc = CMD_BT_ON;
        off  = !p_arg_hits[SECOND_ON];
        if (p_tokens == 2'd1) begin
            if (p_head_hits[FIRST_STATUS]) begin
                v.rc = RES_STATUS;
            end
        end else if (p_tokens == 2'd2) begin
            if (p_head_hits[FIRST_MODE]) begin
                if (p_arg_hits[SECOND_AUTO]) begin
                    v.rc = RES_OK;
                    v.cc = CMD_BOTH_ON;
                end else if (p_arg_hits[SECOND_BT]) begin
                    v.rc = RES_OK;
                    v.cc = CMD_BT_ONLY;
                end else if (p_arg_hits[SECOND_TC]) begin
                    v.rc = RES_OK;
                    v.cc = CMD_TC_ONLY;
                end else if (p_arg_hits[SECOND_OFF]) begin
                    v.rc = RES_OK;
                    v.cc = CMD_BOTH_OFF;
                end
            end else if (p_arg_hits[SECOND_ON] || p_arg_hits[SECOND_OFF]) begin
                if (p_head_hits[FIRST_BT]) begin
                    v.rc = RES_OK;
                    v.cc = off ? CMD_BT_OFF : CMD_BT_ON;
                end else if (p_head_hits[FIRST_TC]) begin
                    v.rc = RES_OK;
                    v.cc = off ? CMD_TC_OFF : CMD_TC_ON;
                end else if (p_head_hits[FIRST_ALL]) begin
                    v.rc = RES_OK;
                    v.cc = off ? CMD_BOTH_OFF : CMD_BOTH_ON;
                end
            end
        end
        return v;
    endfunction

    // Advances the shadow state by one accepted byte; a closing byte yields a verdict.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [7:0] u;
        if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
            end_word();
        end else begin
            u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
            if (!p_in_word) begin
                p_in_word = 1'b1;
                if (p_tokens != 2'd3) begin
                    p_tokens = p_tokens + 2'd1;
                end
                p_pos = 3'd0;
            end
            if (p_tokens == 2'd1) begin
                p_head_hits = prune_letter(p_head_hits, 1'b0, p_pos, u);
            end else if (p_tokens == 2'd2) begin
                p_arg_hits = prune_letter(p_arg_hits, 1'b1, p_pos, u);
            end
            if (p_pos != 3'd7) begin
                p_pos = p_pos + 3'd1;
            end
        end
        if (last) begin
            end_word();
            verdict_q.push_back(judge());
            clear_parse();
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        err_count++;
    endtask

    // Frame building helpers.
    task automatic put_text(input string w);
        for (int i = 0; i < w.len(); i++) begin
            frame_buf.push_back(w[i]);
        end
    endtask

    task automatic put_word(input string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
                c = c + 8'h20;
            end
            frame_buf.push_back(c);
        end
    endtask

    task automatic put_gap(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       frame_buf.push_back(8'h20);
                1:       frame_buf.push_back(8'h09);
                2:       frame_buf.push_back(8'h0D);
                default: frame_buf.push_back(8'h0A);
            endcase
        end
    endtask

    task automatic put_phrase();
        put_gap(0, 1);
        foreach (phrase[i]) begin
            if (i > 0) begin
                put_gap(1, 3);
            end
            put_word(phrase[i]);
        end
        put_gap(0, 1);
    endtask

    // Damages the buffer tail: an extra letter, a lost last byte or a stray byte among the last n.
    task automatic mutate_tail(input int n, input bit high_only);
        int idx;
        idx = frame_buf.size() - n + $urandom_range(0, n - 1);
        if (high_only) begin
            frame_buf[idx] = 8'($urandom_range(128, 255));
        end else begin
            case ($urandom_range(0, 2))
                0: frame_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
                1: if (n > 1) void'(frame_buf.pop_back());
                default: frame_buf[idx] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic flush_frame(input bit hold);
        if (frame_buf.size() == 0) begin
            frame_buf.push_back(8'h20);
        end
        foreach (frame_buf[i]) begin
            beat_q.push_back('{frame_buf[i], i == frame_buf.size() - 1, hold && i == 0});
        end
        frame_buf.delete();
        frame_count++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : sender
        bit offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(beat_q[send_idx].data, beat_q[send_idx].last);
                send_idx++;
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (burst_left == 0 && gap_left == 0) begin
                gap_left   = $urandom_range(0, 7);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_idx < beat_q.size()) begin
                offer = !(beat_q[send_idx].wait_idle && verdict_q.size() != 0);
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= beat_q[send_idx].data;
                s_tlast <= beat_q[send_idx].last;
            end
        end
    end

    // Receiver: a 16-bit ready pattern redrawn each lap, plus occasional long hold-offs.
    logic [15:0] ready_pat = '1;
    logic [3:0]  pat_idx   = 4'd0;
    int          rx_cycle  = 0;
    int          hold_left = 0;

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 250) begin
                hold_left = 80;
            end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
                hold_left = $urandom_range(40, 80);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ready_pat[pat_idx];
                pat_idx = pat_idx + 4'd1;
                if (pat_idx == 4'd0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pat = '1;
                        1:       ready_pat = 16'($urandom);
                        2:       ready_pat = 16'($urandom | $urandom);
                        default: ready_pat = 16'($urandom & $urandom);
                    endcase
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result beat (tdata)", -1, m_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[1:0] != want.rc) begin
                    report_mismatch("result_code", want.rc, m_tdata[1:0]);
                end
                if (m_tdata[4:2] != want.cc) begin
                    report_mismatch("command_code", want.cc, m_tdata[4:2]);
                end
                if (m_tdata[7:5] != 3'd0) begin
                    report_mismatch("tdata padding", 0, m_tdata[7:5]);
                end
                case (want.rc)
                    RES_OK:     n_cmd++;
                    RES_STATUS: n_status++;
                    default:    n_format++;
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    int idle_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles == IDLE_LIMIT) begin
                $display("[%0t] no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int  kind;
        bit  coin;
        bit  first_random;
        string hw;
        string aw;
        clear_parse();

        // Directed frames.
        put_text("STATUS");
        flush_frame(1'b0);
        put_text("bt on");
        flush_frame(1'b0);
        frame_buf.push_back(8'h00);
        flush_frame(1'b0);
        frame_buf.push_back(8'hFF);
        flush_frame(1'b0);
        frame_buf.push_back(8'h0A);
        flush_frame(1'b0);
        put_text("Tc");
        frame_buf.push_back(8'h09);
        put_text("oFF");
        frame_buf.push_back(8'h0D);
        flush_frame(1'b0);
        put_text("all ON");
        flush_frame(1'b0);

        // Random frames, well formed and damaged ones, with random case and spacing.
        first_random = 1'b1;
        while (beat_q.size() < BYTE_TARGET) begin
            phrase.delete();
            kind = $urandom_range(0, 15);
            coin = $urandom_range(0, 1);
            hw   = head_word($urandom_range(0, 4));
            aw   = arg_word($urandom_range(0, 4));
            case (kind)
                0, 1: phrase.push_back(head_word(FIRST_STATUS));
                2, 3: begin
                    phrase.push_back(head_word(FIRST_MODE));
                    phrase.push_back(aw);
                end
                4, 5, 6: begin
                    phrase.push_back(hw);
                    phrase.push_back(coin ? arg_word(SECOND_ON) : arg_word(SECOND_OFF));
                end
                7, 8: begin
                    phrase.push_back(any_word($urandom_range(0, 9)));
                    phrase.push_back(any_word($urandom_range(0, 9)));
                end
                9: begin
                    repeat ($urandom_range(3, 5)) phrase.push_back(any_word($urandom_range(0, 9)));
                end
                14: phrase.push_back(any_word($urandom_range(0, 9)));
                10: begin
                    put_gap(0, 1);
                    put_word(hw);
                    if (coin) mutate_tail(hw.len(), 1'b0);
                    put_gap(1, 2);
                    put_word(aw);
                    if (!coin) mutate_tail(aw.len(), 1'b0);
                end
                11: begin
                    // Tokens longer than any keyword saturate the position counter.
                    if (coin) begin
                        put_word(hw);
                        put_gap(1, 2);
                    end
                    repeat ($urandom_range(7, 11)) begin
                        frame_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
                    end
                    put_gap(0, 1);
                end
                12: begin
                    repeat ($urandom_range(1, 10)) frame_buf.push_back(8'($urandom_range(0, 255)));
                end
                13: put_gap(1, 4);
                default: begin
                    put_word(hw);
                    mutate_tail(hw.len(), 1'b1);
                    if (coin) begin
                        put_gap(1, 2);
                        put_word(aw);
                    end
                end
            endcase
            if (phrase.size() != 0) begin
                put_phrase();
            end
            flush_frame(first_random || $urandom_range(0, 11) == 0);
            first_random = 1'b0;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_idx < beat_q.size() || verdict_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes in %0d frames; checked %0d commands, %0d status requests",
                 beat_q.size(), frame_count, n_cmd, n_status);
        $display("and %0d format errors, with %0d mismatches.", n_format, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
